// ===== hw/rtl/jdd_pkg.sv =====
package jdd_pkg;

    // Default for the longest batch that is accumulated.
    localparam int MAX_BATCH_DEF = 4096;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int POWER_W  = 32;
    localparam int DUTY_W   = 17;
    localparam int FRAC_W   = 16;
    localparam int CNT32_W  = 32;
    localparam int CFG_W    = 32;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 120;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 17'h10000;

    // Configuration register indexes.
    localparam logic REG_POWER_LIMIT = 1'b0;
    localparam logic REG_DUTY_LIMIT  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_I,
        S_SQ_Q,
        S_ACC,
        S_DUTY_GO,
        S_DUTY_WAIT,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_UPDATE
    } t_state;

    // Start request and result strobe of the shared divider.
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;

    // Absolute value of a two's complement sample, one bit wider.
    function automatic logic [MAG_W-1:0] mag16(input logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] ext;
        ext = {s[SAMPLE_W-1], s};
        return s[SAMPLE_W-1] ? (MAG_W'(0) - ext) : ext;
    endfunction

endpackage

// ===== hw/rtl/jdd_div.sv =====
module jdd_div import jdd_pkg::*; #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_rsp         o_rsp,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0] rem_sh;
    logic           ge;
    logic [DEN_W:0] diff;

    // One quotient bit per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom.
    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_quo      = r_num;

endmodule

// ===== hw/rtl/iq_jammer_duty_detector.sv =====
// Channel    | Ports                    | Word
// -----------+--------------------------+-------------------------------------------
// samples in | i_s_axis_t*, o_s_axis_*  | tdata: i_sample, q_sample; tlast: batch_end
// summary    | o_m_axis_t*, i_m_axis_*  | tdata: total, flagged, peak duty, peak power
// config     | i_cfg_we/idx/data        | 0: power_limit, 1: duty_limit
//
// A sample goes through accept, two passes of the one squaring multiplier,
// and the accumulate/compare step; no new sample is taken until they are done.
// A sample closing a batch adds two runs of the shared restoring divider
// and the update step. A sample past MAX_BATCH is accepted and dropped,
// or goes straight to the two divider runs and the update when it closes the batch.
// Reset is synchronous and clears the accumulators, counters, peaks and
// config to their reset values. The summary waits in its output register; a
// full register stalls the next batch update, and no samples are taken while it waits.
module iq_jammer_duty_detector import jdd_pkg::*; #(
    parameter int MAX_BATCH = MAX_BATCH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // i_sample [15:0], q_sample [31:16]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // total_batches [31:0], flagged_batches [63:32], peak_duty [80:64],
    // peak_mean_power [112:81], zeros [119:113]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_BATCH + 1);
    localparam int SUM_W = POWER_W + CNT_W;

    t_state r_state, n_state;

    logic [POWER_W-1:0] r_power_limit;
    logic [DUTY_W-1:0]  r_duty_limit;

    logic [MAG_W-1:0]   r_mag_i, r_mag_q;
    logic               r_last;
    logic [POWER_W-1:0] r_power;

    logic [CNT_W-1:0]   r_cnt, r_over;
    logic [SUM_W-1:0]   r_sum;

    logic [DUTY_W-1:0]  r_duty;
    logic [POWER_W-1:0] r_mean;

    logic [CNT32_W-1:0] r_batches, r_flagged;
    logic [DUTY_W-1:0]  r_duty_peak;
    logic [POWER_W-1:0] r_power_peak;
    logic               r_out_valid;

    logic               accept;
    logic               room;
    logic [MAG_W-1:0]   mul_op;
    logic [2*MAG_W-1:0] mul_res;
    logic               do_update;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic [SUM_W-1:0]   div_num;
    logic [SUM_W-1:0]   div_quo;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign room   = r_cnt < CNT_W'(MAX_BATCH);

    // The single multiplier squares the I magnitude, then the Q magnitude.
    assign mul_op  = (r_state == S_SQ_Q) ? r_mag_q : r_mag_i;
    assign mul_res = mul_op * mul_op;

    assign div_num = (r_state == S_DUTY_GO)
                   ? SUM_W'({r_over, FRAC_W'(0)})
                   : r_sum;

    jdd_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (r_cnt),
        .o_rsp   (div_rsp),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        div_req.start   = 1'b0;
        do_update       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (room) begin
                        n_state = S_SQ_I;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_DUTY_GO;
                    end
                end
            end
            S_SQ_I: n_state = S_SQ_Q;
            S_SQ_Q: n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_DUTY_GO : S_IDLE;
            S_DUTY_GO: begin
                div_req.start = 1'b1;
                n_state       = S_DUTY_WAIT;
            end
            S_DUTY_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_MEAN_GO;
                end
            end
            S_MEAN_GO: begin
                div_req.start = 1'b1;
                n_state       = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    do_update = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sample path payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag_i <= mag16(i_s_axis_tdata[SAMPLE_W-1:0]);
            r_mag_q <= mag16(i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
        end
        if (r_state == S_SQ_I) begin
            r_power <= POWER_W'(mul_res);
        end else if (r_state == S_SQ_Q) begin
            r_power <= r_power + POWER_W'(mul_res);
        end
        if (r_state == S_DUTY_WAIT && div_rsp.done) begin
            r_duty <= div_quo[DUTY_W-1:0];
        end
        if (r_state == S_MEAN_WAIT && div_rsp.done) begin
            r_mean <= div_quo[POWER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= 1'b0;
            r_cnt         <= '0;
            r_over        <= '0;
            r_sum         <= '0;
            r_batches     <= '0;
            r_flagged     <= '0;
            r_duty_peak   <= '0;
            r_power_peak  <= '0;
            r_out_valid   <= 1'b0;
            r_power_limit <= '0;
            r_duty_limit  <= DUTY_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_POWER_LIMIT: r_power_limit <= i_cfg_data;
                    REG_DUTY_LIMIT:  r_duty_limit  <= i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_last <= i_s_axis_tlast;
            end

            if (r_state == S_ACC) begin
                r_sum <= r_sum + SUM_W'(r_power);
                r_cnt <= r_cnt + 1'b1;
                if (r_power >= r_power_limit) begin
                    r_over <= r_over + 1'b1;
                end
            end

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (do_update) begin
                if (r_batches != '1) begin
                    r_batches <= r_batches + 1'b1;
                end
                if (r_duty >= r_duty_limit && r_flagged != '1) begin
                    r_flagged <= r_flagged + 1'b1;
                end
                if (r_duty > r_duty_peak) begin
                    r_duty_peak <= r_duty;
                end
                if (r_mean > r_power_peak) begin
                    r_power_peak <= r_mean;
                end
                r_out_valid <= 1'b1;
                r_cnt       <= '0;
                r_over      <= '0;
                r_sum       <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_power_peak, r_duty_peak, r_flagged, r_batches};

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jdd_pkg::*;

    // A short cap keeps the overlong batch within the run's sample budget.
    localparam int BATCH_CAP     = 256;
    localparam int SETTLE_CYCLES = 250;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PHASE_SAMPLES = 150;
    localparam int NUM_PHASES    = 8;
    localparam int NUM_ROWS      = 21;

    typedef struct packed {
        logic [31:0]       total;
        logic [31:0]       flagged;
        logic [DUTY_W-1:0] duty;
        logic [31:0]       power;
    } t_summary;

    typedef struct packed {
        logic              cfg;       // row writes both limits instead of sending a word
        logic [15:0]       i_val;
        logic [15:0]       q_val;
        logic              last;
        logic [31:0]       power_lim;
        logic [DUTY_W-1:0] duty_lim;
        logic              typed;     // row carries its own expected summary
        t_summary          want;
    } t_row;

    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // Reset limits: every sample counts as hot and every batch is flagged.
        '{1'b0, 16'h0000, 16'h0000, 1'b1, 32'd0, 17'd0, 1'b1,
          '{32'd1, 32'd1, 17'h10000, 32'd0}},
        '{1'b0, 16'h8000, 16'h8000, 1'b1, 32'd0, 17'd0, 1'b1,
          '{32'd2, 32'd2, 17'h10000, 32'h8000_0000}},
        '{1'b0, 16'h7FFF, 16'h7FFF, 1'b1, 32'd0, 17'd0, 1'b1,
          '{32'd3, 32'd3, 17'h10000, 32'h8000_0000}},
        '{1'b0, 16'h7FFF, 16'h8000, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'hFFFF, 16'h0001, 1'b1, 32'd0, 17'd0, 1'b0, '0},
        '{1'b1, 16'h0000, 16'h0000, 1'b0, 32'h8000_0000, 17'd0, 1'b0, '0},
        '{1'b0, 16'h8000, 16'h8000, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h7FFF, 16'h8000, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h0001, 16'hFFFF, 1'b1, 32'd0, 17'd0, 1'b0, '0},
        // Nothing can reach an all-ones power limit or the widest duty limit.
        '{1'b1, 16'h0000, 16'h0000, 1'b0, 32'hFFFF_FFFF, 17'h1FFFF, 1'b0, '0},
        '{1'b0, 16'h8000, 16'h8000, 1'b1, 32'd0, 17'd0, 1'b0, '0},
        // Power equal to the limit counts, duty equal to the limit flags.
        '{1'b1, 16'h0000, 16'h0000, 1'b0, 32'd2, 17'h08000, 1'b0, '0},
        '{1'b0, 16'h0001, 16'h0000, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h0000, 16'hFFFF, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h0001, 16'h0001, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'hFFFF, 16'h0001, 1'b1, 32'd0, 17'd0, 1'b0, '0},
        '{1'b1, 16'h0000, 16'h0000, 1'b0, 32'h4000_0000, 17'h0FFFF, 1'b0, '0},
        '{1'b0, 16'h8000, 16'h7FFF, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h5555, 16'hAAAA, 1'b0, 32'd0, 17'd0, 1'b0, '0},
        '{1'b0, 16'h0000, 16'h0000, 1'b1, 32'd0, 17'd0, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = REG_POWER_LIMIT;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    // Model of the block's state and limits.
    logic [31:0]       power_limit = '0;
    logic [DUTY_W-1:0] duty_limit = DUTY_LIMIT_RST;
    int unsigned       batch_len = 0;
    longint unsigned   energy_sum = 0;
    int unsigned       hot_count = 0;
    logic [31:0]       batches_seen = '0;
    logic [31:0]       batches_flagged = '0;
    logic [DUTY_W-1:0] duty_max = '0;
    logic [31:0]       mean_max = '0;

    t_summary pending_summaries [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int samples_sent = 0;
    int batches_sent = 0;
    int limit_writes = 0;
    int summaries_checked = 0;
    int quiet_cycles = 0;

    iq_jammer_duty_detector #(
        .MAX_BATCH (BATCH_CAP)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Folds one accepted sample into the batch and queues the summary it closes.
    task automatic take_sample(input logic [15:0] iv, input logic [15:0] qv,
                               input logic last, input logic typed, input t_summary want);
        longint          si;
        longint          sq;
        longint unsigned pwr;
        logic [DUTY_W-1:0] duty;
        logic [31:0]     mean;
        t_summary        got;
        if (batch_len < BATCH_CAP) begin
            si = $signed(iv);
            sq = $signed(qv);
            pwr = longint'(si * si + sq * sq);
            energy_sum += pwr;
            if (pwr >= longint'(power_limit))
                hot_count++;
            batch_len++;
        end
        if (last) begin
            duty = DUTY_W'((longint'(hot_count) << 16) / batch_len);
            mean = 32'(energy_sum / batch_len);
            if (batches_seen != 32'hFFFF_FFFF)
                batches_seen++;
            if (duty >= duty_limit && batches_flagged != 32'hFFFF_FFFF)
                batches_flagged++;
            if (duty > duty_max)
                duty_max = duty;
            if (mean > mean_max)
                mean_max = mean;
            batch_len = 0;
            energy_sum = 0;
            hot_count = 0;
            got = '{batches_seen, batches_flagged, duty_max, mean_max};
            pending_summaries.push_back(typed ? want : got);
            batches_sent++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic drive_word(input logic [15:0] iv, input logic [15:0] qv,
                              input logic last, input logic typed, input t_summary want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata <= {qv, iv};
        i_s_axis_tlast <= last;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        take_sample(iv, qv, last, typed, want);
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Upper bits of the duty write are junk that the register must drop.
    task automatic set_limits(input logic [31:0] pl, input logic [DUTY_W-1:0] dl);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_POWER_LIMIT;
        i_cfg_data <= pl;
        @(negedge i_clk);
        i_cfg_idx <= REG_DUTY_LIMIT;
        i_cfg_data <= {15'($urandom), dl};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        power_limit = pl;
        duty_limit = dl;
        limit_writes++;
    endtask

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_summary want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_summaries.size() == 0) begin
                $error("summary word arrived with none expected");
                errors++;
            end else begin
                want = pending_summaries.pop_front();
                check_field("total_batches", want.total, o_m_axis_tdata[31:0]);
                check_field("flagged_batches", want.flagged, o_m_axis_tdata[63:32]);
                check_field("peak_duty", 32'(want.duty), 32'(o_m_axis_tdata[80:64]));
                check_field("peak_mean_power", want.power, o_m_axis_tdata[112:81]);
                check_field("padding", 32'd0, 32'(o_m_axis_tdata[119:113]));
                summaries_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out after %0d cycles without a handshake.", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_row        row;
        int          phase_count;
        int          len;
        logic [31:0] pl;
        logic [DUTY_W-1:0] dl;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.cfg) begin
                wait_idle();
                set_limits(row.power_lim, row.duty_lim);
            end else begin
                drive_word(row.i_val, row.q_val, row.last, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            case (ph)
                0: begin pl = 32'd0;         dl = 17'd0;     end
                1: begin pl = 32'h8000_0000; dl = 17'h10000; end
                2: begin pl = 32'hFFFF_FFFF; dl = 17'h1FFFF; end
                3: begin pl = 32'd1;         dl = 17'h0FFFF; end
                default: begin
                    pl = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 4096))
                                                     : 32'($urandom_range(0, 32'h8000_0000));
                    dl = DUTY_W'($urandom_range(0, 65536));
                end
            endcase
            set_limits(pl, dl);

            // One batch runs past the cap; the extra samples must be dropped.
            if (ph == 4) begin
                len = BATCH_CAP + $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    drive_word(pick_component(), pick_component(), k == len - 1, 1'b0, '0);
            end

            phase_count = 0;
            while (phase_count < PHASE_SAMPLES) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 80)
                                                  : $urandom_range(1, 16);
                for (int k = 0; k < len; k++)
                    drive_word(pick_component(), pick_component(), k == len - 1, 1'b0, '0);
                phase_count += len;
            end
        end

        wait_idle();
        $display("Sent %0d samples in %0d batches under %0d limit settings.",
                 samples_sent, batches_sent, limit_writes);
        $display("Compared %0d summary words, including one batch past the %0d-sample cap.",
                 summaries_checked, BATCH_CAP);
        if (errors == 0 && pending_summaries.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/jdd_pkg.sv
hw/rtl/jdd_div.sv
hw/rtl/iq_jammer_duty_detector.sv
tb/tb.sv
